FILE: design/moving_head_aim_pan_tilt_assert.svh
// Assertion macros for the moving-head aiming block.
`ifndef MOVING_HEAD_AIM_PAN_TILT_ASSERT_SVH
`define MOVING_HEAD_AIM_PAN_TILT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MHAP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MHAP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/mhap_pkg.sv
// Shared types, constants and tables of the moving-head aiming block.
package mhap_pkg;

	localparam int SQRT_STEPS   = 32;
	localparam int NORM_STAGES  = 6;
	localparam int CORDIC_STEPS = 17;
	localparam int ANGLE_LAT    = NORM_STAGES + CORDIC_STEPS + 1;

	localparam int ANG_IN_W = 33;  // angle unit operand width
	localparam int NORM_W   = 41;  // operands normalized to [2^40, 2^41)
	localparam int CW       = 45;  // CORDIC x/y, signed
	localparam int ZW       = 24;  // CORDIC angle accumulator, signed
	localparam int ANG_W    = 23;  // angle 0..90 deg in Q16
	localparam int FRAC     = 16;
	localparam int QW       = 27;  // Q16 degrees up to 720

	localparam logic [ANG_W-1:0] ANG_90 = ANG_W'(90 * 65536);

	localparam logic [QW-1:0] Q_90   = QW'(90 * 65536);
	localparam logic [QW-1:0] Q_180  = QW'(180 * 65536);
	localparam logic [QW-1:0] Q_270  = QW'(270 * 65536);
	localparam logic [QW-1:0] Q_360  = QW'(360 * 65536);
	localparam logic [QW-1:0] Q_540  = QW'(540 * 65536);
	localparam logic [QW-1:0] Q_HALF = QW'(32768);

	localparam logic signed [11:0] DEG_45      = 12'sd45;
	localparam logic signed [11:0] DEG_180     = 12'sd180;
	localparam logic signed [11:0] DEG_270     = 12'sd270;
	localparam logic signed [11:0] DEG_ALT_MAX = 12'sd360;  // 540 - 180

	localparam logic REG_MOUNT_HEIGHT    = 1'b0;
	localparam logic REG_FIXTURE_SPACING = 1'b1;

	typedef struct packed {
		logic [63:0] n;
		logic [63:0] r;
	} sqrt_t;

	typedef struct packed {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [ZW-1:0] z;
		logic                 xz;
		logic                 yz;
	} cordic_t;

	typedef struct packed {
		logic       func;
		logic [9:0] cur_pan;
		logic [8:0] cur_tilt;
		logic       dx_neg;
		logic       dx_zero;
		logic       ty_neg;
	} side_t;

	// arctan(2^-i) in Q16 degrees
	function automatic logic signed [ZW-1:0] atan_q16(input int step);
		logic signed [ZW-1:0] v;
		case (step)
			0:  v = 24'sd2949120;
			1:  v = 24'sd1740967;
			2:  v = 24'sd919879;
			3:  v = 24'sd466945;
			4:  v = 24'sd234379;
			5:  v = 24'sd117304;
			6:  v = 24'sd58666;
			7:  v = 24'sd29335;
			8:  v = 24'sd14668;
			9:  v = 24'sd7334;
			10: v = 24'sd3667;
			11: v = 24'sd1833;
			12: v = 24'sd917;
			13: v = 24'sd458;
			14: v = 24'sd229;
			15: v = 24'sd115;
			16: v = 24'sd57;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: design/mhap_sqrt_cell.sv
// One digit step of the pipelined integer square root.
module mhap_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic            clk,
	input  mhap_pkg::sqrt_t d_in,
	output mhap_pkg::sqrt_t d_s1
);
	import mhap_pkg::*;

	localparam logic [63:0] BIT = 64'(1) << (62 - 2 * STEP);

	logic [63:0] trial;
	sqrt_t       nxt;

	always_comb begin
		trial = d_in.r + BIT;
		if (d_in.n >= trial) begin
			nxt.n = d_in.n - trial;
			nxt.r = (d_in.r >> 1) + BIT;
		end else begin
			nxt.n = d_in.n;
			nxt.r = d_in.r >> 1;
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= nxt;
	end
endmodule

FILE: design/mhap_cordic_cell.sv
// One vectoring CORDIC rotation, shifts truncate toward zero.
module mhap_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic              clk,
	input  mhap_pkg::cordic_t d_in,
	output mhap_pkg::cordic_t d_s1
);
	import mhap_pkg::*;

	localparam logic signed [ZW-1:0] ATAN = atan_q16(STEP);

	logic signed [CW-1:0] sx;
	logic signed [CW-1:0] sy;
	cordic_t              nxt;

	always_comb begin
		sx  = d_in.cy[CW-1] ? -((-d_in.cy) >>> STEP) : (d_in.cy >>> STEP);
		sy  = d_in.cx[CW-1] ? -((-d_in.cx) >>> STEP) : (d_in.cx >>> STEP);
		nxt = d_in;
		if (!d_in.cy[CW-1]) begin
			nxt.cx = d_in.cx + sx;
			nxt.cy = d_in.cy - sy;
			nxt.z  = d_in.z + ATAN;
		end else begin
			nxt.cx = d_in.cx - sx;
			nxt.cy = d_in.cy + sy;
			nxt.z  = d_in.z - ATAN;
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= nxt;
	end
endmodule

FILE: design/mhap_angle.sv
// atan2(y, x) for x, y >= 0: normalize stages, CORDIC cell row, clamp.
module mhap_angle (
	input  logic                          clk,
	input  logic [mhap_pkg::ANG_IN_W-1:0] x,
	input  logic [mhap_pkg::ANG_IN_W-1:0] y,
	output logic [mhap_pkg::ANG_W-1:0]    ang
);
	import mhap_pkg::*;

	cordic_t             nrm [NORM_STAGES+1];
	cordic_t             cch [CORDIC_STEPS+1];
	logic signed [ZW-1:0] z_fin;
	logic [ANG_W-1:0]    ang_nxt;
	logic [ANG_W-1:0]    ang_s1;

	assign nrm[0] = '{cx: {{(CW-ANG_IN_W){1'b0}}, x},
	                  cy: {{(CW-ANG_IN_W){1'b0}}, y},
	                  z:  '0,
	                  xz: (x == '0),
	                  yz: (y == '0)};

	// shift both by 32, 16, ... 1 while the larger stays below 2^41
	for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
		localparam int SH = 32 >> k;
		always_ff @(posedge clk) begin
			if (((nrm[k].cx | nrm[k].cy) >>> (NORM_W - SH)) == '0) begin
				nrm[k+1] <= '{cx: nrm[k].cx <<< SH,
				              cy: nrm[k].cy <<< SH,
				              z:  nrm[k].z,
				              xz: nrm[k].xz,
				              yz: nrm[k].yz};
			end else begin
				nrm[k+1] <= nrm[k];
			end
		end
	end

	assign cch[0] = nrm[NORM_STAGES];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		mhap_cordic_cell #(.STEP(i)) u_cell (
			.clk  (clk),
			.d_in (cch[i]),
			.d_s1 (cch[i+1])
		);
	end

	always_comb begin
		z_fin = cch[CORDIC_STEPS].z;
		if (cch[CORDIC_STEPS].yz)
			ang_nxt = '0;
		else if (cch[CORDIC_STEPS].xz)
			ang_nxt = ANG_90;
		else if (z_fin < 0)
			ang_nxt = '0;
		else if (z_fin > $signed({1'b0, ANG_90}))
			ang_nxt = ANG_90;
		else
			ang_nxt = z_fin[ANG_W-1:0];
	end

	always_ff @(posedge clk) begin
		ang_s1 <= ang_nxt;
	end

	assign ang = ang_s1;
endmodule

FILE: design/moving_head_aim_pan_tilt.sv
// Top level of the moving-head aiming block: pan/tilt from a floor target.
//
//   port group                       | dir | transaction
//   ---------------------------------+-----+----------------------------------
//   start/busy + request fields      | in  | start high, busy low at clk rise
//   done + pan_out/tilt_out/flipped  | out | done high for one cycle
//   wr_en/wr_index/wr_data           | in  | register write when wr_en high
//
// One request per cycle; results leave the pipeline in request order.
// Pipeline: 4 front stages (multiply, delta, squares, sum), 32 square-root
// cells, 24 angle stages (6 normalize, 17 CORDIC cells, clamp), round, output.
// busy stays low: every stage is a register that advances each cycle.
// arst_n clears the in-flight markers and loads both registers with 256.
// done cannot be held off; a result is valid for exactly its one cycle.
module moving_head_aim_pan_tilt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [7:0]  fixture_index,
	input  logic signed [23:0] floor_x,
	input  logic signed [23:0] floor_y,
	input  logic [9:0]  current_pan,
	input  logic [8:0]  current_tilt,
	output logic        done,
	output logic [9:0]  pan_out,
	output logic [8:0]  tilt_out,
	output logic        path_flipped,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [22:0] wr_data
);
	import mhap_pkg::*;

	// stage where both angles are ready, then round and output stages
	localparam int STAGE_ANG = 4 + SQRT_STEPS + ANGLE_LAT;
	localparam int LAT       = STAGE_ANG + 2;
	localparam int PAN_DLY   = STAGE_ANG - 2 - ANGLE_LAT;
	localparam int SIDE_DLY  = STAGE_ANG - 2;

	// config registers
	logic [22:0] height_q;
	logic [22:0] spacing_q;

	// transaction markers, one bit per pipeline stage
	logic [LAT-1:0] valid_q;
	logic           accept;

	// front stages
	logic              func_s1;
	logic [9:0]        cur_pan_s1;
	logic [8:0]        cur_tilt_s1;
	logic signed [23:0] tx_s1;
	logic signed [23:0] ty_s1;
	logic [30:0]       fx_s1;

	logic signed [32:0] dx_c;
	side_t             side_s2;
	logic [31:0]       ax_s2;
	logic [23:0]       ay_s2;

	logic [63:0]       sqx_s3;
	logic [47:0]       sqy_s3;
	logic [63:0]       n_s4;

	// square root cell row
	sqrt_t             sq [SQRT_STEPS+1];
	logic [31:0]       hdist;

	// angles
	logic [ANG_W-1:0]  tilt_ang;
	logic [ANG_W-1:0]  pan_ang;
	logic [ANG_W-1:0]  pan_dly_q [PAN_DLY];
	side_t             side_dly_q [SIDE_DLY];
	side_t             side_a;

	// round stage
	logic [QW-1:0]     p_c;
	logic [QW-1:0]     t_c;
	logic [QW-1:0]     pr_c;
	logic [QW-1:0]     tr_c;
	logic [9:0]        pan_s5;
	logic [8:0]        tilt_s5;
	side_t             side_s5;

	// shortest-path rule
	logic signed [11:0] pan_i;
	logic signed [11:0] cp_i;
	logic signed [11:0] tilt_i;
	logic signed [11:0] ct_i;
	logic signed [11:0] alt_i;
	logic signed [11:0] tdiff_i;
	logic signed [11:0] talt_i;
	logic signed [11:0] dpan_i;
	logic signed [11:0] dalt_i;
	logic              flip_c;
	logic [9:0]        pan_s6;
	logic [8:0]        tilt_s6;
	logic              flip_s6;

	// result range checks
	logic              aim_ok;
	logic              flip_ok;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q  <= 23'd256;
			spacing_q <= 23'd256;
		end else if (wr_en) begin
			case (wr_index)
				REG_MOUNT_HEIGHT:    height_q  <= wr_data;
				REG_FIXTURE_SPACING: spacing_q <= wr_data;
				default:             ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= '0;
		else
			valid_q <= {valid_q[LAT-2:0], accept};
	end

	// s1: fixture position
	always_ff @(posedge clk) begin
		func_s1     <= func;
		cur_pan_s1  <= current_pan;
		cur_tilt_s1 <= current_tilt;
		tx_s1       <= floor_x;
		ty_s1       <= floor_y;
		fx_s1       <= {23'b0, fixture_index} * {8'b0, spacing_q};
	end

	// s2: deltas and magnitudes
	assign dx_c = $signed({{9{tx_s1[23]}}, tx_s1}) - $signed({2'b0, fx_s1});

	always_ff @(posedge clk) begin
		side_s2.func     <= func_s1;
		side_s2.cur_pan  <= cur_pan_s1;
		side_s2.cur_tilt <= cur_tilt_s1;
		side_s2.dx_neg   <= dx_c[32];
		side_s2.dx_zero  <= (dx_c == '0);
		side_s2.ty_neg   <= ty_s1[23];
		ax_s2            <= dx_c[32] ? 32'(-dx_c) : dx_c[31:0];
		ay_s2            <= ty_s1[23] ? 24'(-ty_s1) : 24'(ty_s1);
	end

	// s3, s4: squared distance
	always_ff @(posedge clk) begin
		sqx_s3 <= 64'(ax_s2) * 64'(ax_s2);
		sqy_s3 <= 48'(ay_s2) * 48'(ay_s2);
		n_s4   <= sqx_s3 + 64'(sqy_s3);
	end

	assign sq[0] = '{n: n_s4, r: '0};

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		mhap_sqrt_cell #(.STEP(i)) u_sqrt (
			.clk  (clk),
			.d_in (sq[i]),
			.d_s1 (sq[i+1])
		);
	end

	assign hdist = sq[SQRT_STEPS].r[31:0];

	// tilt angle: atan(hdist / height)
	mhap_angle u_tilt_ang (
		.clk (clk),
		.x   ({{(ANG_IN_W-23){1'b0}}, height_q}),
		.y   ({1'b0, hdist}),
		.ang (tilt_ang)
	);

	// pan angle: atan2(|dy|, |dx|), starts early and waits in a delay line
	mhap_angle u_pan_ang (
		.clk (clk),
		.x   ({1'b0, ax_s2}),
		.y   ({{(ANG_IN_W-24){1'b0}}, ay_s2}),
		.ang (pan_ang)
	);

	always_ff @(posedge clk) begin
		pan_dly_q[0]  <= pan_ang;
		side_dly_q[0] <= side_s2;
		for (int i = 1; i < PAN_DLY; i++)
			pan_dly_q[i] <= pan_dly_q[i-1];
		for (int i = 1; i < SIDE_DLY; i++)
			side_dly_q[i] <= side_dly_q[i-1];
	end

	assign side_a = side_dly_q[SIDE_DLY-1];

	// s5: quadrant correction and rounding to whole degrees
	always_comb begin
		if (!side_a.ty_neg) begin
			if (side_a.dx_zero)
				p_c = Q_180;
			else if (side_a.dx_neg)
				p_c = Q_270 - QW'(pan_dly_q[PAN_DLY-1]);
			else
				p_c = Q_90 + QW'(pan_dly_q[PAN_DLY-1]);
		end else begin
			if (side_a.dx_zero)
				p_c = '0;
			else if (side_a.dx_neg)
				p_c = Q_270 + QW'(pan_dly_q[PAN_DLY-1]);
			else
				p_c = Q_90 - QW'(pan_dly_q[PAN_DLY-1]);
		end
		p_c = p_c + Q_360;
		if (p_c >= Q_540)
			p_c = p_c - Q_360;
		pr_c = p_c + Q_HALF;
		t_c  = Q_180 - QW'(tilt_ang);
		tr_c = t_c + Q_HALF;
	end

	always_ff @(posedge clk) begin
		pan_s5  <= pr_c[FRAC+9:FRAC];
		tilt_s5 <= tr_c[FRAC+8:FRAC];
		side_s5 <= side_a;
	end

	// s6: shortest pan path with mirrored tilt
	always_comb begin
		pan_i   = {2'b0, pan_s5};
		cp_i    = {2'b0, side_s5.cur_pan};
		tilt_i  = {3'b0, tilt_s5};
		ct_i    = {3'b0, side_s5.cur_tilt};
		alt_i   = pan_i;
		if (pan_i < cp_i && pan_i <= DEG_ALT_MAX)
			alt_i = pan_i + DEG_180;
		else if (pan_i > cp_i && pan_i >= DEG_180)
			alt_i = pan_i - DEG_180;
		dpan_i  = (pan_i >= cp_i) ? pan_i - cp_i : cp_i - pan_i;
		dalt_i  = (alt_i >= cp_i) ? alt_i - cp_i : cp_i - alt_i;
		tdiff_i = (tilt_i >= DEG_180) ? tilt_i - DEG_180 : DEG_180 - tilt_i;
		talt_i  = tilt_i;
		if (tilt_i < ct_i)
			talt_i = DEG_180 + tdiff_i;
		else if (tilt_i > ct_i)
			talt_i = DEG_180 - tdiff_i;
		flip_c  = side_s5.func && (dpan_i > dalt_i) &&
		          (talt_i <= DEG_270) && (talt_i >= DEG_45);
	end

	always_ff @(posedge clk) begin
		pan_s6  <= flip_c ? alt_i[9:0] : pan_s5;
		tilt_s6 <= flip_c ? talt_i[8:0] : tilt_s5;
		flip_s6 <= flip_c;
	end

	assign done         = valid_q[LAT-1];
	assign pan_out      = pan_s6;
	assign tilt_out     = tilt_s6;
	assign path_flipped = flip_s6;

	assign aim_ok  = pan_out >= 10'd180 && pan_out <= 10'd540 &&
	                 tilt_out >= 9'd90 && tilt_out <= 9'd180;
	assign flip_ok = pan_out <= 10'd540 && tilt_out >= 9'd45 && tilt_out <= 9'd270;

	`include "moving_head_aim_pan_tilt_assert.svh"

	`MHAP_ASSERT_IMP(a_done_latency, done, $past(accept, LAT), "result without request")
	`MHAP_ASSERT_IMP(a_aim_range, done && !path_flipped, aim_ok, "aim out of range")
	`MHAP_ASSERT_IMP(a_flip_range, done && path_flipped, flip_ok, "flipped result out of range")
	`MHAP_ASSERT_NEXT(a_drained, valid_q == '0, !done, "result from empty pipeline")
endmodule
